// ----- hw/rtl/slse_pkg.sv -----
package slse_pkg;

	localparam int WORD_W      = 32;
	localparam int LIST_DEPTH  = 256;
	localparam int IDX_OUT_W   = 8;
	localparam int CNT_OUT_W   = 9;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic  ins;
		word_t key;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/slse_cell.sv -----
module slse_cell #(
	parameter int IDX = 0,
	parameter int CW  = 9
) (
	input  logic                  clk,
	input  slse_pkg::cell_ctl_t   ctl,
	input  logic [CW-1:0]         count,
	input  slse_pkg::word_t       left_val,
	input  logic                  left_gt,
	output slse_pkg::word_t       val,
	output logic                  gt,
	output logic                  gt_flag,
	output logic                  eq_flag
);

	slse_pkg::word_t val_q;
	logic            gt_q;
	logic            eq_q;
	logic            occ;

	// an empty slot counts as greater than any key
	assign occ = CW'(IDX) < count;
	assign gt  = !occ || (val_q > ctl.key);

	always_ff @(posedge clk) begin
		if (ctl.ins && gt) begin
			val_q <= left_gt ? left_val : ctl.key;
		end
		gt_q <= gt;
		eq_q <= occ && (val_q == ctl.key);
	end

	assign val     = val_q;
	assign gt_flag = gt_q;
	assign eq_flag = eq_q;

endmodule

// ----- hw/rtl/slse_search.sv -----
module slse_search #(
	parameter int LIST_DEPTH = slse_pkg::LIST_DEPTH,
	parameter int AW         = $clog2(LIST_DEPTH),
	parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CW-1:0]         count,
	input  logic [LIST_DEPTH-1:0] gt_vec,
	input  logic [LIST_DEPTH-1:0] eq_vec,
	output logic                  done,
	output logic                  found,
	output logic [AW-1:0]         idx
);

	logic          busy_q;
	logic          done_q;
	logic          found_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] low_q;
	logic [CW-1:0] hi1_q;
	logic [CW-1:0] mid;

	// window is [low, hi1); midpoint low + (high - low) / 2
	assign mid = low_q + ((hi1_q - low_q - CW'(1)) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (low_q >= hi1_q || eq_vec[mid[AW-1:0]]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			low_q   <= '0;
			hi1_q   <= count;
			found_q <= 1'b0;
			idx_q   <= '0;
		end else if (busy_q && low_q < hi1_q) begin
			if (eq_vec[mid[AW-1:0]]) begin
				found_q <= 1'b1;
				idx_q   <= mid[AW-1:0];
			end else if (gt_vec[mid[AW-1:0]]) begin
				hi1_q <= mid;
			end else begin
				low_q <= mid + CW'(1);
			end
		end
	end

	assign done  = done_q;
	assign found = found_q;
	assign idx   = idx_q;

endmodule

// ----- hw/rtl/sorted_list_search_engine_core.sv -----
// Sorted list search engine.
// Holds up to LIST_DEPTH signed 32-bit values in ascending order, one value
// per cell of a shift chain. Requests come in on req_valid/req_stall with
// req_type (insert, search, clear) and value; each transaction yields exactly
// one result transaction on rsp_valid/rsp_stall carrying the list status.
// Insert shifts all larger entries up one cell at once; a full list
// rejects the insert and flags list_full. Search compares the key in every
// cell at once, then a sequencer walks the binary search path one midpoint
// per cycle.
// From accept a request passes through the execute state, then for a search
// the search state, and then the done state, from which the result is
// registered.
// One request is in flight at a time: req_stall is high from accept until the
// result has been loaded into the output register, so the next request can
// be taken while the previous result still waits on rsp_stall.
// While rsp_valid and rsp_stall are both high the result register holds its contents.
// Reset empties the list, zeroes the sum and sets the product to one.
module sorted_list_search_engine_core #(
	parameter int LIST_DEPTH = slse_pkg::LIST_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           req_type,
	input  logic signed [31:0]   value,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 found,
	output logic [7:0]           found_index,
	output logic                 list_full,
	output logic [8:0]           entry_count,
	output logic                 nonempty,
	output logic signed [31:0]   min_value,
	output logic signed [31:0]   max_value,
	output logic signed [31:0]   sum_value,
	output logic signed [31:0]   product_value
);

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [1:0]            req_q;
	slse_pkg::word_t       key_q;
	logic [CW-1:0]         count_q;
	slse_pkg::word_t       sum_q;
	slse_pkg::word_t       prod_q;
	slse_pkg::word_t       max_q;
	logic                  full_q;
	logic                  rsp_valid_q;

	slse_pkg::cell_ctl_t   ctl;
	slse_pkg::word_t       cell_val [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] cell_gt;
	logic [LIST_DEPTH-1:0] gt_vec;
	logic [LIST_DEPTH-1:0] eq_vec;

	logic                  srch_start;
	logic                  srch_done;
	logic                  srch_found;
	logic [AW-1:0]         srch_idx;

	logic                  accept;
	logic                  do_ins;
	logic                  list_at_cap;
	logic                  load_rsp;
	logic [AW+7:0]         idx_ext;
	logic [CW+8:0]         cnt_ext;

	assign accept      = req_valid && !req_stall;
	assign req_stall   = state_q != ST_IDLE;
	assign list_at_cap = count_q == CW'(LIST_DEPTH);
	assign do_ins      = (state_q == ST_EXEC) && (req_q == slse_pkg::REQ_INSERT) && !list_at_cap;
	assign srch_start  = (state_q == ST_EXEC) && (req_q == slse_pkg::REQ_SEARCH);
	assign load_rsp    = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	assign ctl.ins = do_ins;
	assign ctl.key = key_q;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		slse_pkg::word_t lv;
		logic            lg;
		if (i == 0) begin : g_head
			assign lv = key_q;
			assign lg = 1'b0;
		end else begin : g_link
			assign lv = cell_val[i-1];
			assign lg = cell_gt[i-1];
		end
		slse_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count_q),
			.left_val (lv),
			.left_gt  (lg),
			.val      (cell_val[i]),
			.gt       (cell_gt[i]),
			.gt_flag  (gt_vec[i]),
			.eq_flag  (eq_vec[i])
		);
	end

	slse_search #(
		.LIST_DEPTH (LIST_DEPTH),
		.AW         (AW),
		.CW         (CW)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (srch_start),
		.count  (count_q),
		.gt_vec (gt_vec),
		.eq_vec (eq_vec),
		.done   (srch_done),
		.found  (srch_found),
		.idx    (srch_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			prod_q      <= 32'sd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (do_ins) begin
						count_q <= count_q + CW'(1);
						sum_q   <= sum_q + key_q;
						prod_q  <= prod_q * key_q;
					end else if (req_q == slse_pkg::REQ_CLEAR) begin
						count_q <= '0;
						sum_q   <= '0;
						prod_q  <= 32'sd1;
					end
					state_q <= srch_start ? ST_SRCH : ST_DONE;
				end
				ST_SRCH: begin
					if (srch_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			key_q <= value;
		end
		if (state_q == ST_EXEC) begin
			full_q <= (req_q == slse_pkg::REQ_INSERT) && list_at_cap;
		end
		if (do_ins && (count_q == '0 || key_q > max_q)) begin
			max_q <= key_q;
		end
	end

	assign idx_ext = (AW+8)'(srch_idx);
	assign cnt_ext = (CW+9)'(count_q);

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			found         <= (req_q == slse_pkg::REQ_SEARCH) && srch_found;
			found_index   <= ((req_q == slse_pkg::REQ_SEARCH) && srch_found) ?
			                 idx_ext[7:0] : 8'd0;
			list_full     <= full_q;
			entry_count   <= cnt_ext[8:0];
			nonempty      <= count_q != '0;
			min_value     <= (count_q != '0) ? cell_val[0] : '0;
			max_value     <= (count_q != '0) ? max_q : '0;
			sum_value     <= sum_q;
			product_value <= prod_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(LIST_DEPTH))
		else $error("entry count beyond list depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request taken while another in flight");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(srch_done && srch_found) |-> (CW'(srch_idx) < count_q))
		else $error("search hit outside held entries");

	a_nonempty_match: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> (nonempty == (entry_count != 9'd0)))
		else $error("nonempty disagrees with entry count");

endmodule
